>>> design/writable_step_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Step sequencer assertion macros
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef WRITABLE_STEP_SEQUENCER_ASSERT_SVH
`define WRITABLE_STEP_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define WSS_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/wss_pkg.sv
// ----------------------------------------------------------------------------
// Step sequencer package
// Shared widths, types, command codes and rounding constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

  localparam int CV_W   = 15;
  localparam int WORD_W = CV_W + 1;
  localparam int MAG_W  = CV_W - 1;
  localparam int CMD_W  = 4;
  localparam int CH_W   = 2;
  localparam int OP_W   = 3;

  typedef logic signed [CV_W-1:0] cv_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [CMD_W-1:0]       cmd_t;
  typedef logic [OP_W-1:0]        op_t;

  localparam cmd_t CMD_NONE       = 4'd0;
  localparam cmd_t CMD_CLOCK_RISE = 4'd1;
  localparam cmd_t CMD_CLOCK_FALL = 4'd2;
  localparam cmd_t CMD_RESET      = 4'd3;
  localparam cmd_t CMD_RUN        = 4'd4;
  localparam cmd_t CMD_COPY       = 4'd5;
  localparam cmd_t CMD_PASTE      = 4'd6;
  localparam cmd_t CMD_CHANNEL    = 4'd7;
  localparam cmd_t CMD_GATE       = 4'd8;
  localparam cmd_t CMD_LEFT       = 4'd9;
  localparam cmd_t CMD_RIGHT      = 4'd10;
  localparam cmd_t CMD_WINDOW     = 4'd11;
  localparam cmd_t CMD_WRITE      = 4'd12;

  localparam op_t OP_NONE   = 3'd0;
  localparam op_t OP_WRITE  = 3'd1;
  localparam op_t OP_TOGGLE = 3'd2;
  localparam op_t OP_COPY   = 3'd3;
  localparam op_t OP_PASTE  = 3'd4;

  localparam logic [CH_W-1:0] STAGE_CH = 2'd3;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_CLOCK = 2'd1;
  localparam logic [1:0] PEND_WRAP  = 2'd2;

  localparam logic [1:0] PASTE_NOW   = 2'd0;
  localparam logic [1:0] PASTE_CLOCK = 2'd1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PASTE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR   = 3'd4;
  localparam logic [CFG_DATA_W-1:0] NUM_STEPS_RESET = 6'd32;

  localparam word_t CLEAR_WORD = {1'b1, {CV_W{1'b0}}};

  localparam cv_t CV_LIMIT = 15'sd12000;

  // round to nearest 100 cents: q = ((|x| + 50) * 5243) >> 19, exact below 2^14
  localparam int RECIP_W   = 13;
  localparam int PROD_W    = MAG_W + 1 + RECIP_W;
  localparam int RND_SHIFT = 19;
  localparam int Q_W       = 7;
  localparam logic [MAG_W-1:0]   RND_BIAS  = 14'd50;
  localparam logic [RECIP_W-1:0] RND_RECIP = 13'd5243;

endpackage

`default_nettype wire

>>> design/writable_step_sequencer.sv
// ----------------------------------------------------------------------------
// Writable four-channel step sequencer
// Each input request is one panel or clock event with a CV sample; each one
// returns a single result with the three CV outputs, gates and panel state.
// Channels: input and output use valid/ready; config writes use cfg_valid,
// cfg_index and cfg_data and are always taken (cfg_ready is tied high).
// A request runs through a small sequencer that walks one step store with
// one write port and one read port: it rounds the CV, then does a
// read-modify-write for a write or gate toggle, or a pass over all
// MAX_STEPS steps for a copy or paste, then reads the store to gather
// outputs, loads the output register and returns to idle to take the next
// request; in_ready is high only between requests.
// Reset is synchronous. After reset a clearing pass fills all
// 4 * 2^clog2(MAX_STEPS) step store entries (128 by default) and the clip
// store; no request is taken meanwhile, config writes are.
// A stalled receiver holds the result in the output register; the next
// request is taken and worked on, and its result waits until the old one
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "writable_step_sequencer_assert.svh"

module writable_step_sequencer import wss_pkg::*; #(
  parameter int MAX_STEPS = 32,
  localparam int IDX_W = $clog2(MAX_STEPS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cmd_t                  command,
  input  logic [2:0]            button_index,
  input  cv_t                   cv_in,
  input  logic                  gate_in_present,
  input  logic                  gate_in_high,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cv_t                   cv_out_a,
  output cv_t                   cv_out_b,
  output cv_t                   cv_out_c,
  output logic [2:0]            gate_outs,
  output logic [IDX_W-1:0]      shown_step,
  output logic [CH_W-1:0]       current_channel,
  output logic                  is_running,
  output logic                  edit_allowed,
  output logic [1:0]            paste_pending,
  output logic [CH_W-1:0]       paste_target,
  output logic [7:0]            page_gates,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W       = IDX_W + 1;
  localparam int SA_W        = IDX_W + 2;
  localparam int CMPW        = (CNT_W > 6) ? CNT_W : 6;
  localparam int STORE_DEPTH = 4 << IDX_W;
  localparam int CLIP_DEPTH  = 1 << IDX_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_MEM    = 3'd3;
  localparam logic [2:0] S_GATHER = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [SA_W-1:0] CLEAR_LAST  = '1;
  localparam logic [SA_W-1:0] COPY_LAST   = SA_W'(MAX_STEPS);
  localparam logic [SA_W-1:0] RMW_LAST    = SA_W'(1);
  localparam logic [SA_W-1:0] GATHER_LAST = SA_W'(11);
  localparam logic [3:0]      GATHER_CV   = 4'd3;

  // configuration
  logic [CFG_DATA_W-1:0] num_steps;
  logic                  auto_advance;
  logic                  quantize_on;
  logic [1:0]            paste_mode;
  logic                  monitor_steps;

  // sequencer state
  logic [2:0]      state;
  logic [SA_W-1:0] cnt;
  logic [IDX_W-1:0] play_index, play_index_next;
  logic [IDX_W-1:0] stage_index, stage_index_next;
  logic [CH_W-1:0]  channel_sel, channel_sel_next;
  logic             run_flag, run_flag_next;
  logic [1:0]       pending_kind, pending_kind_next;
  logic [CH_W-1:0]  pending_channel, pending_channel_next;
  logic             clock_level, clock_level_next;
  op_t              mem_op, mem_op_next;
  logic [SA_W-1:0]  mem_addr, mem_addr_next;
  logic             wr_gate_present, wr_gate_high;

  // request decode
  logic [CMPW-1:0]  ns_wide, len_wide, win, win_idx;
  logic [CNT_W-1:0] len;
  logic [IDX_W-1:0] last_idx, pi, si, ep, ep_new, tog, pn;
  logic             ep_set, stage_sel, can_edit, accept;

  // gather
  cv_t              stored_cv [3];
  logic [2:0]       stored_gate;
  logic [7:0]       page_bits;
  logic [7:0]       page_ok;
  logic [IDX_W-1:0] edit_index, page_base, mem_prev;
  logic [3:0]       rd_slot, cap_slot;
  logic [2:0]       page_slot;
  logic             mem_last, out_load;
  cv_t              cv_pick [3];
  logic [2:0]       gate_pick;

  // memories
  logic             store_we, clip_we;
  logic [SA_W-1:0]  store_waddr, store_raddr;
  logic [IDX_W-1:0] clip_waddr, clip_raddr;
  word_t            store_wdata, store_rdata, clip_wdata, clip_rdata;

  // rounding unit
  logic rnd_done;
  cv_t  rnd_cv;

  function automatic logic [IDX_W-1:0] step_right(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc >= n) ? '0 : IDX_W'(inc);
  endfunction

  function automatic logic [IDX_W-1:0] step_left(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] lastv);
    return (idx == '0) ? lastv : IDX_W'(idx - IDX_W'(1));
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps     <= NUM_STEPS_RESET;
      auto_advance  <= 1'b1;
      quantize_on   <= 1'b1;
      paste_mode    <= PASTE_NOW;
      monitor_steps <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_STEPS: num_steps     <= cfg_data;
        CFG_AUTO:      auto_advance  <= cfg_data[0];
        CFG_QUANTIZE:  quantize_on   <= cfg_data[0];
        CFG_PASTE:     paste_mode    <= cfg_data[1:0];
        CFG_MONITOR:   monitor_steps <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ns_wide = CMPW'(num_steps);
    if (ns_wide == '0) begin
      len_wide = CMPW'(1);
    end else if (ns_wide > CMPW'(MAX_STEPS)) begin
      len_wide = CMPW'(MAX_STEPS);
    end else begin
      len_wide = ns_wide;
    end
    len      = CNT_W'(len_wide);
    last_idx = IDX_W'(len - CNT_W'(1));
  end

  always_comb begin
    pi        = (CNT_W'(play_index) >= len) ? last_idx : play_index;
    si        = (CNT_W'(stage_index) >= len) ? last_idx : stage_index;
    stage_sel = (channel_sel == STAGE_CH);
    can_edit  = !run_flag || stage_sel;
    ep        = stage_sel ? si : pi;
    ep_new    = ep;
    ep_set    = 1'b0;
    tog       = (ep & ~IDX_W'(7)) | IDX_W'(button_index);
    win       = CMPW'({button_index, 3'b000});
    win_idx   = win | CMPW'(ep[2:0]);
    pn        = step_right(pi, len);

    play_index_next      = pi;
    stage_index_next     = si;
    channel_sel_next     = channel_sel;
    run_flag_next        = run_flag;
    pending_kind_next    = pending_kind;
    pending_channel_next = pending_channel;
    clock_level_next     = clock_level;
    mem_op_next          = OP_NONE;
    mem_addr_next        = {channel_sel, ep};

    unique case (command)
      CMD_CLOCK_RISE: begin
        if (!clock_level && run_flag) begin
          play_index_next = pn;
          if (pending_kind == PEND_CLOCK || (pending_kind == PEND_WRAP && pn == '0)) begin
            mem_op_next       = OP_PASTE;
            mem_addr_next     = {pending_channel, {IDX_W{1'b0}}};
            pending_kind_next = PEND_NONE;
          end
        end
        clock_level_next = 1'b1;
      end
      CMD_CLOCK_FALL: clock_level_next = 1'b0;
      CMD_RESET: begin
        play_index_next  = '0;
        stage_index_next = '0;
      end
      CMD_RUN: begin
        run_flag_next     = !run_flag;
        pending_kind_next = PEND_NONE;
      end
      CMD_COPY: begin
        mem_op_next   = OP_COPY;
        mem_addr_next = {channel_sel, {IDX_W{1'b0}}};
      end
      CMD_PASTE: begin
        if (paste_mode == PASTE_NOW || stage_sel) begin
          mem_op_next       = OP_PASTE;
          mem_addr_next     = {channel_sel, {IDX_W{1'b0}}};
          pending_kind_next = PEND_NONE;
        end else begin
          pending_kind_next    = (paste_mode == PASTE_CLOCK) ? PEND_CLOCK : PEND_WRAP;
          pending_channel_next = channel_sel;
        end
      end
      CMD_CHANNEL: channel_sel_next = channel_sel + CH_W'(1);
      CMD_GATE: begin
        if (CNT_W'(tog) < CNT_W'(MAX_STEPS)) begin
          mem_op_next   = OP_TOGGLE;
          mem_addr_next = {channel_sel, tog};
        end
      end
      CMD_LEFT: begin
        if (can_edit) begin
          ep_new = step_left(ep, last_idx);
          ep_set = 1'b1;
        end
      end
      CMD_RIGHT: begin
        if (can_edit) begin
          ep_new = step_right(ep, len);
          ep_set = 1'b1;
        end
      end
      CMD_WINDOW: begin
        if (can_edit && win < CMPW'(MAX_STEPS)) begin
          ep_new = (win_idx >= CMPW'(len)) ? last_idx : IDX_W'(win_idx);
          ep_set = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (can_edit) begin
          mem_op_next = OP_WRITE;
          if (auto_advance) begin
            ep_new = step_right(ep, len);
            ep_set = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (ep_set) begin
      if (stage_sel) begin
        stage_index_next = ep_new;
      end else begin
        play_index_next = ep_new;
      end
    end
  end

  wss_round u_round (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .cv_in    (cv_in),
    .quantize (quantize_on),
    .done     (rnd_done),
    .cv_out   (rnd_cv)
  );

  assign edit_index = (channel_sel == STAGE_CH) ? stage_index : play_index;
  assign page_base  = edit_index & ~IDX_W'(7);
  assign mem_prev   = IDX_W'(cnt - SA_W'(1));
  assign rd_slot    = cnt[3:0];
  assign cap_slot   = rd_slot - 4'd1;
  assign page_slot  = 3'(cap_slot - GATHER_CV);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      page_ok[i] = CNT_W'(page_base | IDX_W'(i)) < CNT_W'(MAX_STEPS);
    end
  end

  always_comb begin
    if (mem_op == OP_COPY || mem_op == OP_PASTE) begin
      mem_last = (cnt == COPY_LAST);
    end else begin
      mem_last = (cnt == RMW_LAST);
    end
  end

  always_comb begin
    store_we    = 1'b0;
    store_waddr = mem_addr;
    store_wdata = CLEAR_WORD;
    clip_we     = 1'b0;
    clip_waddr  = cnt[IDX_W-1:0];
    clip_wdata  = store_rdata;
    clip_raddr  = cnt[IDX_W-1:0];
    if (rd_slot < GATHER_CV) begin
      store_raddr = {rd_slot[CH_W-1:0], play_index};
    end else begin
      store_raddr = {channel_sel, page_base | IDX_W'(3'(rd_slot - GATHER_CV))};
    end

    unique case (state)
      S_CLEAR: begin
        store_we    = 1'b1;
        store_waddr = cnt;
        clip_we     = 1'b1;
        clip_wdata  = CLEAR_WORD;
      end
      S_MEM: begin
        unique case (mem_op)
          OP_WRITE: begin
            store_raddr = mem_addr;
            store_we    = (cnt == RMW_LAST);
            store_wdata = {wr_gate_present ? wr_gate_high : store_rdata[CV_W], rnd_cv};
          end
          OP_TOGGLE: begin
            store_raddr = mem_addr;
            store_we    = (cnt == RMW_LAST);
            store_wdata = {~store_rdata[CV_W], store_rdata[CV_W-1:0]};
          end
          OP_COPY: begin
            store_raddr = {mem_addr[SA_W-1 -: CH_W], cnt[IDX_W-1:0]};
            clip_we     = (cnt != '0);
            clip_waddr  = mem_prev;
          end
          OP_PASTE: begin
            store_we    = (cnt != '0);
            store_waddr = {mem_addr[SA_W-1 -: CH_W], mem_prev};
            store_wdata = clip_rdata;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  wss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  wss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CLIP_DEPTH)
  ) u_clip (
    .clk   (clk),
    .we    (clip_we),
    .waddr (clip_waddr),
    .wdata (clip_wdata),
    .raddr (clip_raddr),
    .rdata (clip_rdata)
  );

  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      cnt             <= '0;
      play_index      <= '0;
      stage_index     <= '0;
      channel_sel     <= '0;
      run_flag        <= 1'b1;
      pending_kind    <= PEND_NONE;
      pending_channel <= '0;
      clock_level     <= 1'b0;
      mem_op          <= OP_NONE;
      out_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + SA_W'(1);
          if (cnt == CLEAR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state           <= S_ROUND;
            play_index      <= play_index_next;
            stage_index     <= stage_index_next;
            channel_sel     <= channel_sel_next;
            run_flag        <= run_flag_next;
            pending_kind    <= pending_kind_next;
            pending_channel <= pending_channel_next;
            clock_level     <= clock_level_next;
            mem_op          <= mem_op_next;
          end
        end
        S_ROUND: begin
          if (rnd_done) begin
            cnt   <= '0;
            state <= (mem_op == OP_NONE) ? S_GATHER : S_MEM;
          end
        end
        S_MEM: begin
          if (mem_last) begin
            cnt   <= '0;
            state <= S_GATHER;
          end else begin
            cnt <= cnt + SA_W'(1);
          end
        end
        S_GATHER: begin
          cnt <= cnt + SA_W'(1);
          if (cnt == GATHER_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_addr        <= mem_addr_next;
      wr_gate_present <= gate_in_present;
      wr_gate_high    <= gate_in_high;
    end
    if (state == S_GATHER && cnt != '0) begin
      if (cap_slot < GATHER_CV) begin
        stored_cv[cap_slot[1:0]]   <= store_rdata[CV_W-1:0];
        stored_gate[cap_slot[1:0]] <= store_rdata[CV_W];
      end else begin
        page_bits[page_slot] <= store_rdata[CV_W] & page_ok[page_slot];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cv_pick[i]   = (run_flag || monitor_steps) ? stored_cv[i] : rnd_cv;
      gate_pick[i] = run_flag ? (clock_level && stored_gate[i])
                              : (channel_sel == CH_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cv_out_a        <= cv_pick[0];
      cv_out_b        <= cv_pick[1];
      cv_out_c        <= cv_pick[2];
      gate_outs       <= gate_pick;
      shown_step      <= edit_index;
      current_channel <= channel_sel;
      is_running      <= run_flag;
      edit_allowed    <= !run_flag || (channel_sel == STAGE_CH);
      paste_pending   <= pending_kind;
      paste_target    <= pending_channel;
      page_gates      <= page_bits;
    end
  end

  `WSS_CHECK_NEXT(a_busy_after_accept, accept, !in_ready, "request taken while busy")
  `WSS_CHECK_NOW(a_no_write_idle, state == S_IDLE, !store_we && !clip_we, "store write while idle")
  `WSS_CHECK_NOW(a_result_from_done, $rose(out_valid), $past(state) == S_DONE, "result without gather")

endmodule

`default_nettype wire

>>> design/wss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/wss_round.sv
// ----------------------------------------------------------------------------
// CV saturate and semitone round
// Three-stage unit: saturate, reciprocal multiply, rebuild and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_round import wss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cv_t  cv_in,
  input  logic quantize,
  output logic done,
  output cv_t  cv_out
);

  logic             sat_neg;
  logic [MAG_W-1:0] sat_mag;
  logic             v0, v1, v2;
  logic             neg0, neg1;
  logic             quant0, quant1;
  logic [MAG_W-1:0] mag0, mag1;
  logic [MAG_W:0]   biased;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]   q1;
  logic [MAG_W-1:0] semis;
  logic [MAG_W-1:0] mag_out;

  always_comb begin
    if (cv_in > CV_LIMIT) begin
      sat_neg = 1'b0;
      sat_mag = MAG_W'(CV_LIMIT);
    end else if (cv_in < -CV_LIMIT) begin
      sat_neg = 1'b1;
      sat_mag = MAG_W'(CV_LIMIT);
    end else begin
      sat_neg = cv_in[CV_W-1];
      sat_mag = sat_neg ? MAG_W'(-cv_in) : MAG_W'(cv_in);
    end
  end

  assign biased  = (MAG_W + 1)'(mag0) + (MAG_W + 1)'(RND_BIAS);
  assign prod    = PROD_W'(biased) * PROD_W'(RND_RECIP);
  assign semis   = MAG_W'({q1, 6'b0}) + MAG_W'({q1, 5'b0}) + MAG_W'({q1, 2'b0});
  assign mag_out = quant1 ? semis : mag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg0   <= sat_neg;
      mag0   <= sat_mag;
      quant0 <= quantize;
    end
    if (v0) begin
      neg1   <= neg0;
      mag1   <= mag0;
      quant1 <= quant0;
      q1     <= prod[RND_SHIFT +: Q_W];
    end
    if (v1) begin
      cv_out <= neg1 ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
    end
  end

  assign done = v2;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Step sequencer testbench
// Sends panel and clock events with random handshake gaps on both sides.
// Each event is run through an internal model of the step store, clip buffer
// and panel state, and every returned result is compared field by field with
// the oldest prediction. Configuration changes only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;
  import wss_pkg::*;

  localparam int STEPS         = 32;
  localparam int IDX_W         = $clog2(STEPS);
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 100;

  localparam cmd_t CMD_UNUSED_LO = 4'd13;
  localparam cmd_t CMD_UNUSED_HI = 4'd15;

  typedef struct {
    cv_t              cv_a;
    cv_t              cv_b;
    cv_t              cv_c;
    logic [2:0]       gates;
    logic [IDX_W-1:0] step;
    logic [CH_W-1:0]  chan;
    logic             running;
    logic             editable;
    logic [1:0]       pend;
    logic [CH_W-1:0]  target;
    logic [7:0]       page;
  } panel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  cmd_t                  command = CMD_NONE;
  logic [2:0]            button_index = 3'd0;
  cv_t                   cv_in = '0;
  logic                  gate_in_present = 1'b0;
  logic                  gate_in_high = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cv_t                   cv_out_a;
  cv_t                   cv_out_b;
  cv_t                   cv_out_c;
  logic [2:0]            gate_outs;
  logic [IDX_W-1:0]      shown_step;
  logic [CH_W-1:0]       current_channel;
  logic                  is_running;
  logic                  edit_allowed;
  logic [1:0]            paste_pending;
  logic [CH_W-1:0]       paste_target;
  logic [7:0]            page_gates;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_NUM_STEPS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  writable_step_sequencer #(.MAX_STEPS(STEPS)) dut (.*);

  // sequencer model
  cv_t             step_cv [4][STEPS];
  logic            step_gate [4][STEPS];
  cv_t             clip_cv [STEPS];
  logic            clip_gate [STEPS];
  int              play_pos;
  int              stage_pos;
  logic [CH_W-1:0] sel_ch;
  logic [CH_W-1:0] pend_ch;
  logic [1:0]      pend_kind;
  logic            running;
  logic            clock_high;
  int              len_setting;
  logic            auto_step;
  logic            quantize;
  logic [1:0]      paste_setting;
  logic            monitor;

  panel_t predicted_panels[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     error_count = 0;
  int     stall_cycles = 0;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic check_field(input string fname, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", fname, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    panel_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_panels.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("result with no request outstanding");
        end
      end else begin
        want = predicted_panels.pop_front();
        check_field("cv_out_a", want.cv_a, cv_out_a);
        check_field("cv_out_b", want.cv_b, cv_out_b);
        check_field("cv_out_c", want.cv_c, cv_out_c);
        check_field("gate_outs", want.gates, gate_outs);
        check_field("shown_step", want.step, shown_step);
        check_field("current_channel", want.chan, current_channel);
        check_field("is_running", want.running, is_running);
        check_field("edit_allowed", want.editable, edit_allowed);
        check_field("paste_pending", want.pend, paste_pending);
        check_field("paste_target", want.target, paste_target);
        check_field("page_gates", want.page, page_gates);
      end
    end
  end

  function automatic int wrap_right(input int idx, input int n);
    return (idx + 1 >= n) ? 0 : idx + 1;
  endfunction

  task automatic paste_clip(input logic [CH_W-1:0] ch);
    for (int s = 0; s < STEPS; s++) begin
      step_cv[ch][s] = clip_cv[s];
      step_gate[ch][s] = clip_gate[s];
    end
  endtask

  task automatic predict_panel(input cmd_t cmd, input logic [2:0] btn, input cv_t cv,
                               input logic present, input logic level, output panel_t res);
    int         n;
    int         c;
    int         cq;
    int         idx;
    int         s;
    logic       editable;
    logic       moved;
    cv_t        cvo [3];
    logic [2:0] gates;
    logic [7:0] page;
    n = (len_setting < 1) ? 1 : (len_setting > STEPS) ? STEPS : len_setting;
    c = cv;
    if (c > int'(CV_LIMIT)) c = int'(CV_LIMIT);
    if (c < -int'(CV_LIMIT)) c = -int'(CV_LIMIT);
    cq = !quantize ? c : (c >= 0) ? ((c + 50) / 100) * 100 : -(((50 - c) / 100) * 100);
    if (play_pos >= n) play_pos = n - 1;
    if (stage_pos >= n) stage_pos = n - 1;
    editable = !running || sel_ch == STAGE_CH;
    idx = (sel_ch == STAGE_CH) ? stage_pos : play_pos;
    moved = 1'b0;
    case (cmd)
      CMD_CLOCK_RISE: begin
        if (!clock_high && running) begin
          play_pos = wrap_right(play_pos, n);
          if (pend_kind == PEND_CLOCK || (pend_kind == PEND_WRAP && play_pos == 0)) begin
            paste_clip(pend_ch);
            pend_kind = PEND_NONE;
          end
        end
        clock_high = 1'b1;
      end
      CMD_CLOCK_FALL: clock_high = 1'b0;
      CMD_RESET: begin
        play_pos = 0;
        stage_pos = 0;
      end
      CMD_RUN: begin
        running = !running;
        pend_kind = PEND_NONE;
      end
      CMD_COPY: begin
        for (s = 0; s < STEPS; s++) begin
          clip_cv[s] = step_cv[sel_ch][s];
          clip_gate[s] = step_gate[sel_ch][s];
        end
      end
      CMD_PASTE: begin
        if (paste_setting == PASTE_NOW || sel_ch == STAGE_CH) begin
          paste_clip(sel_ch);
          pend_kind = PEND_NONE;
        end else begin
          pend_kind = (paste_setting == PASTE_CLOCK) ? PEND_CLOCK : PEND_WRAP;
          pend_ch = sel_ch;
        end
      end
      CMD_CHANNEL: sel_ch = sel_ch + 1'b1;
      CMD_GATE: begin
        s = (idx & ~7) | int'(btn);
        if (s < STEPS) step_gate[sel_ch][s] = !step_gate[sel_ch][s];
      end
      CMD_LEFT: if (editable) begin
        idx = (idx == 0 || idx - 1 >= n) ? n - 1 : idx - 1;
        moved = 1'b1;
      end
      CMD_RIGHT: if (editable) begin
        idx = wrap_right(idx, n);
        moved = 1'b1;
      end
      CMD_WINDOW: if (editable && int'(btn) * 8 < STEPS) begin
        idx = int'(btn) * 8 + (idx & 7);
        if (idx >= n) idx = n - 1;
        moved = 1'b1;
      end
      CMD_WRITE: if (editable) begin
        step_cv[sel_ch][idx] = cv_t'(cq);
        if (present) step_gate[sel_ch][idx] = level;
        if (auto_step) idx = wrap_right(idx, n);
        moved = 1'b1;
      end
      default: ;
    endcase
    if (moved) begin
      if (sel_ch == STAGE_CH) stage_pos = idx;
      else play_pos = idx;
    end

    for (int i = 0; i < 3; i++) begin
      if (running) begin
        cvo[i] = step_cv[i][play_pos];
        gates[i] = clock_high && step_gate[i][play_pos];
      end else begin
        cvo[i] = monitor ? step_cv[i][play_pos] : cv_t'(cq);
        gates[i] = (sel_ch == i);
      end
    end
    idx = (sel_ch == STAGE_CH) ? stage_pos : play_pos;
    for (int i = 0; i < 8; i++) begin
      s = (idx & ~7) | i;
      page[i] = (s < STEPS) && step_gate[sel_ch][s];
    end
    res.cv_a = cvo[0];
    res.cv_b = cvo[1];
    res.cv_c = cvo[2];
    res.gates = gates;
    res.step = IDX_W'(idx);
    res.chan = sel_ch;
    res.running = running;
    res.editable = !running || sel_ch == STAGE_CH;
    res.pend = pend_kind;
    res.target = pend_ch;
    res.page = page;
  endtask

  function automatic cv_t rand_cv();
    case ($urandom_range(3))
      0: return cv_t'($urandom);
      1: return cv_t'(int'($urandom_range(24000)) - 12000);
      2: return cv_t'(int'($urandom_range(240)) * 100 - 12000 + int'($urandom_range(2)) * 50 - 50);
      default: return cv_t'(int'($urandom_range(200)) - 100);
    endcase
  endfunction

  task automatic send_request(input cmd_t cmd, input logic [2:0] btn, input cv_t cv,
                              input logic present, input logic level);
    panel_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    button_index <= btn;
    cv_in <= cv;
    gate_in_present <= present;
    gate_in_high <= level;
    // hold the request until accepted
    do @(posedge clk); while (!in_ready);
    predict_panel(cmd, btn, cv, present, level, want);
    predicted_panels.push_back(want);
  endtask

  task automatic send_cmd(input cmd_t cmd);
    send_request(cmd, 3'($urandom), rand_cv(), 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_panels.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NUM_STEPS: len_setting = int'(data);
      CFG_AUTO:      auto_step = data[0];
      CFG_QUANTIZE:  quantize = data[0];
      CFG_PASTE:     paste_setting = data[1:0];
      CFG_MONITOR:   monitor = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_cmd(CMD_CLOCK_RISE);
      if ($urandom_range(9) != 0) send_cmd(CMD_CLOCK_FALL);
    end else if (pick < 52) begin
      send_cmd(CMD_WRITE);
    end else if (pick < 59) begin
      send_cmd(CMD_LEFT);
    end else if (pick < 65) begin
      send_cmd(CMD_RIGHT);
    end else if (pick < 69) begin
      send_cmd(CMD_WINDOW);
    end else if (pick < 76) begin
      send_cmd(CMD_GATE);
    end else if (pick < 81) begin
      send_cmd(CMD_CHANNEL);
    end else if (pick < 87) begin
      send_cmd(CMD_RUN);
    end else if (pick < 90) begin
      send_cmd(CMD_COPY);
    end else if (pick < 94) begin
      send_cmd(CMD_PASTE);
    end else if (pick < 96) begin
      send_cmd(CMD_RESET);
    end else if (pick < 98) begin
      send_cmd(CMD_NONE);
    end else begin
      send_cmd(cmd_t'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)));
    end
  endtask

  task automatic test_directed_events();
    send_request(CMD_NONE, 3'd7, CV_LIMIT, 1'b1, 1'b1);
    send_request(CMD_CLOCK_RISE, 3'd0, -CV_LIMIT, 1'b0, 1'b0);
    send_request(CMD_CLOCK_RISE, 3'd0, '0, 1'b0, 1'b0);
    send_cmd(CMD_CLOCK_FALL);
    send_request(CMD_WRITE, 3'd0, cv_t'(1234), 1'b1, 1'b0);
    send_request(CMD_GATE, 3'd7, '0, 1'b0, 1'b0);
    send_cmd(CMD_RUN);
    send_request(CMD_WRITE, 3'd0, cv_t'(15'h3fff), 1'b1, 1'b0);
    send_request(CMD_WRITE, 3'd0, cv_t'(15'h4000), 1'b0, 1'b1);
    send_request(CMD_WRITE, 3'd0, cv_t'(150), 1'b1, 1'b1);
    send_request(CMD_WRITE, 3'd0, cv_t'(-150), 1'b1, 1'b0);
    send_request(CMD_WRITE, 3'd0, cv_t'(149), 1'b0, 1'b0);
    send_cmd(CMD_LEFT);
    send_request(CMD_WINDOW, 3'd3, '0, 1'b0, 1'b0);
    send_request(CMD_WINDOW, 3'd4, '0, 1'b0, 1'b0);
    send_cmd(CMD_RIGHT);
    send_cmd(CMD_RESET);
    send_cmd(CMD_LEFT);
    send_cmd(CMD_COPY);
    repeat (3) send_cmd(CMD_CHANNEL);
    send_cmd(CMD_PASTE);
    send_cmd(CMD_CHANNEL);
    send_cmd(CMD_UNUSED_LO);
    send_cmd(CMD_UNUSED_HI);
    send_cmd(CMD_RUN);
  endtask

  task automatic test_length_extremes();
    wait_drained();
    write_register(CFG_MONITOR, 6'd1);
    if (running) send_cmd(CMD_RUN);
    send_request(CMD_WINDOW, 3'd3, rand_cv(), 1'b1, 1'b1);
    send_cmd(CMD_RIGHT);
    wait_drained();
    write_register(CFG_NUM_STEPS, 6'd1);
    send_cmd(CMD_RIGHT);
    send_cmd(CMD_LEFT);
    send_cmd(CMD_WRITE);
    send_cmd(CMD_RUN);
    send_cmd(CMD_CLOCK_RISE);
    send_cmd(CMD_CLOCK_FALL);
    wait_drained();
    write_register(CFG_NUM_STEPS, 6'd0);
    repeat (8) send_random_request();
    wait_drained();
    write_register(CFG_NUM_STEPS, 6'd63);
    send_cmd(CMD_RESET);
    if (running) send_cmd(CMD_RUN);
    send_cmd(CMD_LEFT);
    wait_drained();
    write_register(CFG_NUM_STEPS, 6'd5);
    send_request(CMD_WINDOW, 3'd1, rand_cv(), 1'b0, 1'b0);
    repeat (8) send_random_request();
  endtask

  task automatic test_paste_timing();
    wait_drained();
    write_register(CFG_NUM_STEPS, 6'd4);
    write_register(CFG_PASTE, CFG_DATA_W'(PASTE_CLOCK));
    if (!running) send_cmd(CMD_RUN);
    send_cmd(CMD_CLOCK_FALL);
    while (sel_ch != STAGE_CH) send_cmd(CMD_CHANNEL);
    send_cmd(CMD_CHANNEL);
    send_cmd(CMD_COPY);
    send_cmd(CMD_CHANNEL);
    send_cmd(CMD_PASTE);
    send_cmd(CMD_CLOCK_RISE);
    send_cmd(CMD_CLOCK_FALL);
    send_cmd(CMD_CHANNEL);
    wait_drained();
    write_register(CFG_PASTE, 6'd2);
    send_cmd(CMD_PASTE);
    repeat (5) begin
      send_cmd(CMD_CLOCK_RISE);
      send_cmd(CMD_CLOCK_FALL);
    end
    send_cmd(CMD_PASTE);
    send_cmd(CMD_RUN);
    send_cmd(CMD_RUN);
    wait_drained();
    write_register(CFG_PASTE, 6'd3);
    send_cmd(CMD_PASTE);
    repeat (5) begin
      send_cmd(CMD_CLOCK_RISE);
      send_cmd(CMD_CLOCK_FALL);
    end
    send_cmd(CMD_CHANNEL);
    send_cmd(CMD_PASTE);
    send_cmd(CMD_CHANNEL);
  endtask

  task automatic test_random_mix(input int count);
    int sent;
    logic [CFG_DATA_W-1:0] len;
    sent = 0;
    while (sent < count) begin
      wait_drained();
      case ($urandom_range(3))
        0: len = 6'd1;
        1: len = 6'd32;
        2: len = 6'($urandom_range(8, 2));
        default: len = 6'($urandom_range(32, 1));
      endcase
      write_register(CFG_NUM_STEPS, len);
      write_register(CFG_AUTO, 6'($urandom_range(1)));
      write_register(CFG_QUANTIZE, 6'($urandom_range(1)));
      write_register(CFG_PASTE, 6'($urandom_range(3)));
      write_register(CFG_MONITOR, 6'($urandom_range(1)));
      repeat (count / 5) begin
        send_random_request();
        sent++;
      end
    end
  endtask

  initial begin
    for (int ch = 0; ch < 4; ch++) begin
      for (int s = 0; s < STEPS; s++) begin
        step_cv[ch][s] = '0;
        step_gate[ch][s] = 1'b1;
      end
    end
    for (int s = 0; s < STEPS; s++) begin
      clip_cv[s] = '0;
      clip_gate[s] = 1'b1;
    end
    play_pos = 0;
    stage_pos = 0;
    sel_ch = '0;
    pend_ch = '0;
    pend_kind = PEND_NONE;
    running = 1'b1;
    clock_high = 1'b0;
    len_setting = int'(NUM_STEPS_RESET);
    auto_step = 1'b1;
    quantize = 1'b1;
    paste_setting = PASTE_NOW;
    monitor = 1'b0;

    send_idle_pct = 31;
    recv_idle_pct = 88;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_length_extremes();
    test_paste_timing();
    test_random_mix(250);
    send_idle_pct = 88;
    recv_idle_pct = 31;
    test_random_mix(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(250);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && predicted_panels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (predicted_panels.size() != 0) begin
        $display("%0d results never arrived", predicted_panels.size());
      end
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
